/* sv/imm_pkg.sv */
// Shared types and constants for the integer matrix multiply unit.
`timescale 1ns / 1ps
package imm_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned IdxW  = 3;
  localparam int unsigned DimW  = 4;
  localparam int unsigned Slots = 8;
  localparam int unsigned AddrW = 2 * IdxW;
  localparam int unsigned Depth = 64;

  localparam logic [1:0] OP_WR_A = 2'd0;
  localparam logic [1:0] OP_WR_B = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_IDX = 2'd1;
  localparam logic [1:0] ST_DIM = 2'd2;

  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef struct packed {
    logic             vld;
    logic             first;
    logic             lastk;
    logic [IdxW-1:0]  k;
    logic [DataW-1:0] a;
  } token_t;
endpackage

/* sv/imm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* sv/imm_cell.sv */
// One column cell: holds a column of B, multiplies passing A elements and accumulates.
`timescale 1ns / 1ps
module imm_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       b_we_i,
  input  logic [imm_pkg::IdxW-1:0]   b_row_i,
  input  logic [imm_pkg::DataW-1:0]  b_val_i,
  input  imm_pkg::token_t            tok_i,
  output imm_pkg::token_t            tok_o,
  output logic                       done_o,
  output logic [imm_pkg::DataW-1:0]  acc_o
);
  import imm_pkg::*;

  logic [DataW-1:0] b_q [Slots];
  token_t           tok_q;
  logic [DataW-1:0] prod_q;
  logic             pv_q, pf_q, pl_q;
  logic [DataW-1:0] acc_q;
  logic             done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) b_q[i] <= '0;
      tok_q  <= '0;
      pv_q   <= 1'b0;
      pf_q   <= 1'b0;
      pl_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      if (b_we_i) b_q[b_row_i] <= b_val_i;
      tok_q  <= tok_i;
      pv_q   <= tok_i.vld;
      pf_q   <= tok_i.first;
      pl_q   <= tok_i.lastk;
      done_q <= pv_q & pl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= tok_i.a * b_q[tok_i.k];
    if (pv_q) acc_q <= pf_q ? prod_q : acc_q + prod_q;
  end

  assign tok_o  = tok_q;
  assign done_o = done_q;
  assign acc_o  = acc_q;
endmodule

/* sv/integer_matrix_multiply_unit.sv */
// Top level of the integer matrix multiply unit: command decode, A store, cell chain.
`timescale 1ns / 1ps
// Element writes and refused commands each give one result the cycle after they are
// accepted. A multiply holds busy high; A is read one element a cycle from its
// RAM and streamed through a chain of column cells, each owning a column of B. The
// issue of each row of A is paced by the single A read port and by the row's b_cols
// results leaving one a cycle. The final product is registered at the edge at which
// busy drops. Results appear at most one per cycle on valid_o and cannot be held off
// by the receiver.
module integer_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic [imm_pkg::IdxW-1:0]  row_i,
  input  logic [imm_pkg::IdxW-1:0]  col_i,
  input  logic [imm_pkg::DataW-1:0] value_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [imm_pkg::DimW-1:0]  cfg_wdata_i,
  output logic                      valid_o,
  output logic [1:0]                status_o,
  output logic [imm_pkg::IdxW-1:0]  out_row_o,
  output logic [imm_pkg::IdxW-1:0]  out_col_o,
  output logic [imm_pkg::DataW-1:0] product_o,
  output logic                      last_o
);
  import imm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN} state_e;

  localparam logic [DimW-1:0] MaxDim = DimW'(MAX_DIM);

  state_e           state_q;
  logic [DimW-1:0]  a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic [DimW-1:0]  clamp;
  logic             accept, in_rng, lim_ok;
  logic [IdxW-1:0]  i_q, s_q, oi_q, oj_q;
  logic [DimW-1:0]  lim;
  logic [Depth-1:0] av_q;
  logic             avr_q;
  logic [AddrW-1:0] raddr;
  logic [DataW-1:0] rdata;
  logic             ram_we;
  token_t           iss_q;
  token_t           tok [MAX_DIM+1];
  logic [MAX_DIM-1:0] done, mask;
  logic [DataW-1:0] acc [MAX_DIM];
  logic             any_done, out_last;
  logic [DataW-1:0] sel_acc;

  assign busy   = (state_q != S_IDLE);
  assign accept = start & ~busy;

  always_comb begin
    clamp = cfg_wdata_i;
    if (cfg_wdata_i == '0) clamp = DimW'(1);
    else if (cfg_wdata_i > MaxDim) clamp = MaxDim;
  end

  always_comb begin
    if (op_i == OP_WR_A) in_rng = ({1'b0, row_i} < a_rows_q) && ({1'b0, col_i} < a_cols_q);
    else in_rng = ({1'b0, row_i} < b_rows_q) && ({1'b0, col_i} < b_cols_q);
  end

  assign ram_we = accept && (op_i == OP_WR_A) && in_rng;
  assign lim    = ((a_cols_q > b_cols_q) ? a_cols_q : b_cols_q) - DimW'(1);
  assign lim_ok = ({1'b0, s_q} == lim);
  assign raddr  = {i_q, s_q};

  imm_ram #(.Width(DataW), .Depth(Depth)) u_a_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i ({row_i, col_i}),
    .wdata_i (value_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    tok[0]   = iss_q;
    tok[0].a = avr_q ? rdata : '0;
  end

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
    imm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .b_we_i  (accept && (op_i == OP_WR_B) && in_rng && (col_i == IdxW'(j))),
      .b_row_i (row_i),
      .b_val_i (value_i),
      .tok_i   (tok[j]),
      .tok_o   (tok[j+1]),
      .done_o  (done[j]),
      .acc_o   (acc[j])
    );
    assign mask[j] = (DimW'(j) < b_cols_q);
  end

  always_comb begin
    sel_acc = '0;
    for (int j = MAX_DIM - 1; j >= 0; j--) begin
      if (done[j] && mask[j]) sel_acc = acc[j];
    end
  end

  assign any_done = |(done & mask);
  assign out_last = ({1'b0, oi_q} == a_rows_q - DimW'(1)) &&
                    ({1'b0, oj_q} == b_cols_q - DimW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      a_rows_q <= DimW'(1);
      a_cols_q <= DimW'(1);
      b_rows_q <= DimW'(1);
      b_cols_q <= DimW'(1);
      av_q     <= '0;
      avr_q    <= 1'b0;
      iss_q    <= '0;
      i_q      <= '0;
      s_q      <= '0;
      oi_q     <= '0;
      oj_q     <= '0;
      valid_o  <= 1'b0;
      status_o <= ST_OK;
      out_row_o <= '0;
      out_col_o <= '0;
      product_o <= '0;
      last_o   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_A_ROWS: a_rows_q <= clamp;
          REG_A_COLS: a_cols_q <= clamp;
          REG_B_ROWS: b_rows_q <= clamp;
          REG_B_COLS: b_cols_q <= clamp;
          default: ;
        endcase
      end
      if (ram_we) av_q[{row_i, col_i}] <= 1'b1;
      avr_q     <= av_q[raddr];
      iss_q     <= '0;
      valid_o   <= 1'b0;
      status_o  <= ST_OK;
      out_row_o <= '0;
      out_col_o <= '0;
      product_o <= '0;
      last_o    <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            case (op_i)
              OP_WR_A, OP_WR_B: begin
                valid_o  <= 1'b1;
                last_o   <= 1'b1;
                status_o <= in_rng ? ST_OK : ST_IDX;
              end
              OP_MUL: begin
                if (a_cols_q != b_rows_q) begin
                  valid_o  <= 1'b1;
                  last_o   <= 1'b1;
                  status_o <= ST_DIM;
                end else begin
                  state_q <= S_RUN;
                  i_q  <= '0;
                  s_q  <= '0;
                  oi_q <= '0;
                  oj_q <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          iss_q.vld   <= ({1'b0, s_q} < a_cols_q);
          iss_q.first <= (s_q == '0);
          iss_q.lastk <= ({1'b0, s_q} == a_cols_q - DimW'(1));
          iss_q.k     <= s_q;
          if (lim_ok) begin
            s_q <= '0;
            if ({1'b0, i_q} == a_rows_q - DimW'(1)) state_q <= S_DRAIN;
            else i_q <= i_q + IdxW'(1);
          end else begin
            s_q <= s_q + IdxW'(1);
          end
        end
        S_DRAIN: ;
        default: state_q <= S_IDLE;
      endcase

      if (any_done) begin
        valid_o   <= 1'b1;
        out_row_o <= oi_q;
        out_col_o <= oj_q;
        product_o <= sel_acc;
        last_o    <= out_last;
        if (out_last) state_q <= S_IDLE;
        if ({1'b0, oj_q} == b_cols_q - DimW'(1)) begin
          oj_q <= '0;
          oi_q <= oi_q + IdxW'(1);
        end else begin
          oj_q <= oj_q + IdxW'(1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_one_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(done & mask)) else $error("two cells finished in one cycle");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_done |-> busy) else $error("cell result outside a multiply");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (any_done && out_last) |=> !busy) else $error("busy after final product");
  a_no_run_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> !(valid_o && status_o != ST_OK))
    else $error("error result during multiply");
`endif
endmodule

/* tb/imm_checker.sv */
// Checker for the integer matrix multiply unit: predicts each request's results and compares.
`timescale 1ns / 1ps
module imm_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [1:0]                op_i,
  input  logic [imm_pkg::IdxW-1:0]  row_i,
  input  logic [imm_pkg::IdxW-1:0]  col_i,
  input  logic [imm_pkg::DataW-1:0] value_i,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [imm_pkg::DimW-1:0]  cfg_wdata_i,
  input  logic                      valid_i,
  input  logic [1:0]                status_i,
  input  logic [imm_pkg::IdxW-1:0]  out_row_i,
  input  logic [imm_pkg::IdxW-1:0]  out_col_i,
  input  logic [imm_pkg::DataW-1:0] product_i,
  input  logic                      last_i,
  output int                        errors_o,
  output int                        pending_o,
  output int                        results_o
);
  import imm_pkg::*;

  typedef struct packed {
    logic [1:0]       status;
    logic [IdxW-1:0]  row;
    logic [IdxW-1:0]  col;
    logic [DataW-1:0] product;
    logic             last;
  } elem_res_t;

  logic [DataW-1:0] left_mem [Depth];
  logic [DataW-1:0] right_mem [Depth];
  logic [DimW-1:0]  dim [4];
  elem_res_t        awaited [$];

  assign pending_o = awaited.size();

  function automatic logic [DimW-1:0] sat_dim(logic [DimW-1:0] v);
    if (v == 0) return DimW'(1);
    if (v > 8) return DimW'(8);
    return v;
  endfunction

  function automatic elem_res_t mk(logic [1:0] st, int r, int c, logic [DataW-1:0] p,
                                   logic l);
    elem_res_t e;
    e.status = st; e.row = r[IdxW-1:0]; e.col = c[IdxW-1:0]; e.product = p; e.last = l;
    return e;
  endfunction

  task automatic predict_request(logic [1:0] op, logic [IdxW-1:0] r, logic [IdxW-1:0] c,
                                 logic [DataW-1:0] v);
    logic [DimW-1:0]  nr;
    logic [DimW-1:0]  nc;
    logic [DataW-1:0] acc;
    if (op == OP_WR_A || op == OP_WR_B) begin
      nr = (op == OP_WR_A) ? dim[REG_A_ROWS] : dim[REG_B_ROWS];
      nc = (op == OP_WR_A) ? dim[REG_A_COLS] : dim[REG_B_COLS];
      if (r >= nr || c >= nc) begin
        awaited.push_back(mk(ST_IDX, 0, 0, 0, 1'b1));
      end else begin
        if (op == OP_WR_A) left_mem[{r, c}] = v;
        else right_mem[{r, c}] = v;
        awaited.push_back(mk(ST_OK, 0, 0, 0, 1'b1));
      end
    end else if (op == OP_MUL) begin
      if (dim[REG_A_COLS] != dim[REG_B_ROWS]) begin
        awaited.push_back(mk(ST_DIM, 0, 0, 0, 1'b1));
      end else begin
        for (int i = 0; i < dim[REG_A_ROWS]; i++) begin
          for (int j = 0; j < dim[REG_B_COLS]; j++) begin
            acc = '0;
            for (int k = 0; k < dim[REG_A_COLS]; k++)
              acc = acc + left_mem[i*8+k] * right_mem[k*8+j];
            awaited.push_back(mk(ST_OK, i, j, acc,
                                 i == dim[REG_A_ROWS] - 1 && j == dim[REG_B_COLS] - 1));
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    elem_res_t e;
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        left_mem[i] = '0;
        right_mem[i] = '0;
      end
      for (int i = 0; i < 4; i++) dim[i] = DimW'(1);
      awaited.delete();
      errors_o = 0;
      results_o = 0;
    end else begin
      if (valid_i) begin
        results_o++;
        if (awaited.size() == 0) begin
          $error("result with nothing expected: status %0d product %0h", status_i, product_i);
          errors_o++;
        end else begin
          e = awaited.pop_front();
          if (status_i !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_i); errors_o++;
          end
          if (out_row_i !== e.row) begin
            $error("out_row: expected %0d, got %0d", e.row, out_row_i); errors_o++;
          end
          if (out_col_i !== e.col) begin
            $error("out_col: expected %0d, got %0d", e.col, out_col_i); errors_o++;
          end
          if (product_i !== e.product) begin
            $error("product: expected %0h, got %0h", e.product, product_i); errors_o++;
          end
          if (last_i !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, last_i); errors_o++;
          end
        end
      end
      if (start_i && !busy_i) predict_request(op_i, row_i, col_i, value_i);
      if (cfg_we_i) dim[cfg_idx_i] = sat_dim(cfg_wdata_i);
    end
  end
endmodule

/* tb/tb_integer_matrix_multiply_unit.sv */
// Testbench top for the integer matrix multiply unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_integer_matrix_multiply_unit;
  import imm_pkg::*;

  localparam int Settle   = 100;
  localparam int MaxCycle = 300000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       op_i = OP_WR_A;
  logic [IdxW-1:0]  row_i = '0;
  logic [IdxW-1:0]  col_i = '0;
  logic [DataW-1:0] value_i = '0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = REG_A_ROWS;
  logic [DimW-1:0]  cfg_wdata_i = '0;
  logic             valid_o;
  logic [1:0]       status_o;
  logic [IdxW-1:0]  out_row_o;
  logic [IdxW-1:0]  out_col_o;
  logic [DataW-1:0] product_o;
  logic             last_o;
  int               errors, pending, results;
  int               cycles = 0;
  int               sent = 0;
  int               multiplies = 0;
  bit               calm = 1'b0;
  logic [DimW-1:0]  cur_dim [4];

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycle) begin
      $display("Some tests failed");
      $finish;
    end
  end

  integer_matrix_multiply_unit i_dut (.*);

  imm_checker i_checker (
    .clk_i, .rst_ni, .start_i(start), .busy_i(busy), .op_i, .row_i, .col_i, .value_i,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .valid_i(valid_o), .status_i(status_o),
    .out_row_i(out_row_o), .out_col_i(out_col_o), .product_i(product_o),
    .last_i(last_o), .errors_o(errors), .pending_o(pending), .results_o(results)
  );

  task automatic send(logic [1:0] op, logic [IdxW-1:0] r, logic [IdxW-1:0] c,
                      logic [DataW-1:0] v);
    start <= 1'b1; op_i <= op; row_i <= r; col_i <= c; value_i <= v;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
    if (op == OP_MUL) multiplies++;
    if (!calm && $urandom_range(3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // only called while drained
  task automatic set_dims(logic [DimW-1:0] ar, logic [DimW-1:0] ac, logic [DimW-1:0] br,
                          logic [DimW-1:0] bc);
    logic [DimW-1:0] v [4];
    v = '{ar, ac, br, bc};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1; cfg_idx_i <= i[1:0]; cfg_wdata_i <= v[i];
      cur_dim[i] = (v[i] == 0) ? DimW'(1) : (v[i] > 8) ? DimW'(8) : v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [DataW-1:0] rand_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(15) - 8;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int              pick;
    logic [1:0]      op;
    logic [DimW-1:0] nr, nc;
    logic [IdxW-1:0] r, c;
    pick = $urandom_range(99);
    op = (pick < 45) ? OP_WR_A : (pick < 87) ? OP_WR_B : (pick < 96) ? OP_MUL : 2'd3;
    nr = (op == OP_WR_B) ? cur_dim[REG_B_ROWS] : cur_dim[REG_A_ROWS];
    nc = (op == OP_WR_B) ? cur_dim[REG_B_COLS] : cur_dim[REG_A_COLS];
    if ($urandom_range(9) < 8) begin
      r = IdxW'($urandom_range(nr - 1));
      c = IdxW'($urandom_range(nc - 1));
    end else begin
      r = IdxW'($urandom_range(7));
      c = IdxW'($urandom_range(7));
    end
    send(op, r, c, rand_value());
  endtask

  initial begin
    logic [DimW-1:0] ar, ac, bc;
    for (int i = 0; i < 4; i++) cur_dim[i] = DimW'(1);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset sizes, zero stores
    send(OP_MUL, 3'd5, 3'd2, 32'hdead_beef);
    send(OP_WR_A, 3'd0, 3'd1, 32'd1);
    send(2'd3, 3'd7, 3'd7, 32'hffff_ffff);
    drain();
    set_dims(4'd2, 4'd2, 4'd2, 4'd2);
    send(OP_WR_A, 3'd0, 3'd0, 32'h8000_0000);
    send(OP_WR_A, 3'd0, 3'd1, 32'h7fff_ffff);
    send(OP_WR_A, 3'd1, 3'd0, 32'hffff_ffff);
    send(OP_WR_A, 3'd1, 3'd1, 32'd0);
    send(OP_WR_B, 3'd0, 3'd0, 32'h8000_0000);
    send(OP_WR_B, 3'd0, 3'd1, 32'hffff_ffff);
    send(OP_WR_B, 3'd1, 3'd0, 32'h7fff_ffff);
    send(OP_WR_B, 3'd1, 3'd1, 32'd3);
    send(OP_WR_B, 3'd2, 3'd0, 32'd9);
    send(OP_WR_A, 3'd0, 3'd7, 32'd9);
    send(OP_WR_A, 3'd7, 3'd7, 32'd9);
    send(OP_MUL, 3'd0, 3'd0, 32'd0);
    drain();
    // saturating size writes: zero and above the maximum
    set_dims(4'd0, 4'd15, 4'd9, 4'd8);
    send(OP_WR_A, 3'd7, 3'd7, 32'h1234_5678);
    send(OP_WR_B, 3'd7, 3'd7, 32'h8765_4321);
    send(OP_WR_A, 3'd0, 3'd7, 32'd5);
    send(OP_WR_A, 3'd1, 3'd0, 32'd5);
    send(OP_MUL, 3'd0, 3'd0, 32'd0);
    drain();
    set_dims(4'd3, 4'd2, 4'd4, 4'd5);
    send(OP_MUL, 3'd0, 3'd0, 32'd0);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      calm = (ph == 9);
      if (ph == 0) begin
        ar = 4'd8; ac = 4'd8; bc = 4'd8;
      end else if (ph == 1) begin
        ar = 4'd1; ac = 4'd1; bc = 4'd1;
      end else begin
        ar = DimW'($urandom_range(4, 1));
        ac = DimW'($urandom_range(4, 1));
        bc = DimW'($urandom_range(4, 1));
        if ($urandom_range(3) == 0) begin
          ar = DimW'($urandom_range(8, 1)); bc = DimW'($urandom_range(8, 1));
        end
      end
      set_dims(ar, ac, ($urandom_range(4) == 0) ? DimW'($urandom_range(15)) : ac, bc);
      repeat (32) random_request();
      send(OP_MUL, 3'd0, 3'd0, 32'd0);
      drain();
    end

    $display("Covered %0d requests (%0d multiplies) giving %0d results,", sent, multiplies,
             results);
    $display("over random and extreme matrix sizes including saturated size writes.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
